>>> hdl/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
`default_nettype none
package spa_pkg;

  localparam int MAX_TERMS_DEF = 16;
  localparam int COEFF_W       = 32;
  localparam int EXP_W         = 8;
  localparam int DATA_W        = 40;
  localparam int IN_USER_W     = 4;
  localparam int OUT_USER_W    = 4;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [1:0] TAB_A   = 2'd0;
  localparam logic [1:0] TAB_B   = 2'd1;
  localparam logic [1:0] TAB_SUM = 2'd2;
  localparam logic [1:0] TAB_BAD = 2'd3;

  localparam logic [2:0] STAT_NEW  = 3'd0;
  localparam logic [2:0] STAT_COMB = 3'd1;
  localparam logic [2:0] STAT_FULL = 3'd2;
  localparam logic [2:0] STAT_READ = 3'd3;
  localparam logic [2:0] STAT_ADD  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,
    S_INS_CHK,
    S_INS_PLACE,
    S_INS_SHIFT,
    S_INS_MOVE,
    S_INS_END,
    S_ADD_NEXT,
    S_ADD_FETCH,
    S_RD_ISSUE,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

>>> hdl/sparse_polynomial_adder.sv
// Top level of the sparse polynomial adder: term memory and its sequencer.
`default_nettype none
// Three term tables (A, B, sum) of MAX_TERMS entries each share one
// single-port-read, single-port-write memory with a registered read port;
// per-table term counts sit in registers and clear at reset. One input word
// is taken at a time. An insert scans the entries up to the first exponent
// not below the new one; an equal exponent is combined in place, else, unless
// the table is full, the higher entries shift up one place and the new term
// is written. An add runs that insert once per term of A and B, up to
// 2*MAX_TERMS inserts into the sum table. A read fetches and emits the terms
// in turn and waits while the output is stalled. A result word waits in the
// output register while the next input word is accepted.
module sparse_polynomial_adder #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // coeff_in[31:0], exp_in[39:32]
  input  wire logic [spa_pkg::DATA_W-1:0]     s_tdata,
  // cmd[1:0], table_sel[3:2]
  input  wire logic [spa_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // coeff_out[31:0], exp_out[39:32]
  output logic [spa_pkg::DATA_W-1:0]          m_tdata,
  // status[2:0], empty_res[3]
  output logic [spa_pkg::OUT_USER_W-1:0]      m_tuser,
  output logic                                m_tlast
);
  import spa_pkg::*;

  localparam int DEPTH = 3 * MAX_TERMS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_TERMS + 1);
  localparam int EW    = COEFF_W + EXP_W;

  function automatic logic [AW-1:0] addr_of(logic [1:0] t, logic [CW-1:0] i);
    return AW'(AW'(t) * AW'(MAX_TERMS)) + AW'(i);
  endfunction

  function automatic logic [COEFF_W-1:0] sat_add(logic [COEFF_W-1:0] a,
                                                 logic [COEFF_W-1:0] b);
    logic [COEFF_W:0] s;
    s = {a[COEFF_W-1], a} + {b[COEFF_W-1], b};
    if (s[COEFF_W] != s[COEFF_W-1]) begin
      return s[COEFF_W] ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
    end
    return s[COEFF_W-1:0];
  endfunction

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  logic [COEFF_W-1:0] rd_coeff;
  logic [EXP_W-1:0]   rd_exp;
  assign rd_coeff = rd_data[COEFF_W-1:0];
  assign rd_exp   = rd_data[EW-1:COEFF_W];

  state_t             state, state_next;
  logic [CW-1:0]      count [3];
  logic [CW-1:0]      count_next [3];
  logic [1:0]         tab, tab_next;
  logic               add_mode, add_mode_next;
  logic [COEFF_W-1:0] ins_coeff, ins_coeff_next;
  logic [EXP_W-1:0]   ins_exp, ins_exp_next;
  logic [CW-1:0]      idx, idx_next;
  logic [CW-1:0]      pos, pos_next;
  logic               src_tab, src_tab_next;
  logic [CW-1:0]      src_idx, src_idx_next;
  logic               dropped, dropped_next;
  logic [2:0]         emit_status, emit_status_next;
  logic               emit_empty, emit_empty_next;
  logic               emit_term, emit_term_next;
  logic               m_valid_next;
  logic [DATA_W-1:0]  m_data_next;
  logic [OUT_USER_W-1:0] m_user_next;
  logic               m_last_next;

  logic [1:0]         in_cmd, in_sel, rd_tab;
  logic [CW-1:0]      n_cur, n_src;
  logic               out_free, term_last;

  assign in_cmd   = s_tuser[1:0];
  assign in_sel   = s_tuser[3:2];
  assign rd_tab   = (in_sel == TAB_BAD) ? TAB_SUM : in_sel;
  assign n_cur    = count[tab];
  assign n_src    = count[{1'b0, src_tab}];
  assign out_free = !m_tvalid || m_tready;
  assign term_last = (CW'(idx + CW'(1)) == n_cur);
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count[0] <= '0;
      count[1] <= '0;
      count[2] <= '0;
      m_tvalid <= 1'b0;
      add_mode <= 1'b0;
    end else begin
      state    <= state_next;
      count[0] <= count_next[0];
      count[1] <= count_next[1];
      count[2] <= count_next[2];
      m_tvalid <= m_valid_next;
      add_mode <= add_mode_next;
    end
  end

  always_ff @(posedge clk) begin
    tab         <= tab_next;
    ins_coeff   <= ins_coeff_next;
    ins_exp     <= ins_exp_next;
    idx         <= idx_next;
    pos         <= pos_next;
    src_tab     <= src_tab_next;
    src_idx     <= src_idx_next;
    dropped     <= dropped_next;
    emit_status <= emit_status_next;
    emit_empty  <= emit_empty_next;
    emit_term   <= emit_term_next;
    m_tdata     <= m_data_next;
    m_tuser     <= m_user_next;
    m_tlast     <= m_last_next;
  end

  always_comb begin
    state_next       = state;
    count_next[0]    = count[0];
    count_next[1]    = count[1];
    count_next[2]    = count[2];
    tab_next         = tab;
    add_mode_next    = add_mode;
    ins_coeff_next   = ins_coeff;
    ins_exp_next     = ins_exp;
    idx_next         = idx;
    pos_next         = pos;
    src_tab_next     = src_tab;
    src_idx_next     = src_idx;
    dropped_next     = dropped;
    emit_status_next = emit_status;
    emit_empty_next  = emit_empty;
    emit_term_next   = emit_term;
    m_valid_next     = m_tvalid && !m_tready;
    m_data_next      = m_tdata;
    m_user_next      = m_tuser;
    m_last_next      = m_tlast;
    rd_en            = 1'b0;
    rd_addr          = addr_of(tab, idx);
    wr_en            = 1'b0;
    wr_addr          = addr_of(tab, idx);
    wr_data          = rd_data;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          emit_empty_next = 1'b0;
          emit_term_next  = 1'b0;
          idx_next        = '0;
          case (in_cmd)
            CMD_INSERT: begin
              if (in_sel == TAB_BAD) begin
                emit_status_next = STAT_FULL;
                state_next       = S_EMIT;
              end else begin
                tab_next       = in_sel;
                ins_coeff_next = s_tdata[COEFF_W-1:0];
                ins_exp_next   = s_tdata[EW-1:COEFF_W];
                add_mode_next  = 1'b0;
                state_next     = S_INS_SCAN;
              end
            end
            CMD_ADD: begin
              count_next[2] = '0;
              src_tab_next  = 1'b0;
              src_idx_next  = '0;
              dropped_next  = 1'b0;
              add_mode_next = 1'b1;
              state_next    = S_ADD_NEXT;
            end
            CMD_READ: begin
              tab_next         = rd_tab;
              emit_status_next = STAT_READ;
              if (count[rd_tab] == '0) begin
                emit_empty_next = 1'b1;
                state_next      = S_EMIT;
              end else begin
                emit_term_next = 1'b1;
                state_next     = S_RD_ISSUE;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_INS_SCAN: begin
        if (idx == n_cur) begin
          pos_next   = idx;
          state_next = S_INS_PLACE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        if (rd_exp < ins_exp) begin
          idx_next   = CW'(idx + CW'(1));
          state_next = S_INS_SCAN;
        end else if (rd_exp == ins_exp) begin
          wr_en            = 1'b1;
          wr_data          = {rd_exp, sat_add(rd_coeff, ins_coeff)};
          emit_status_next = STAT_COMB;
          state_next       = S_INS_END;
        end else begin
          pos_next   = idx;
          state_next = S_INS_PLACE;
        end
      end
      S_INS_PLACE: begin
        if (n_cur == CW'(MAX_TERMS)) begin
          emit_status_next = STAT_FULL;
          state_next       = S_INS_END;
        end else begin
          idx_next   = n_cur;
          state_next = S_INS_SHIFT;
        end
      end
      S_INS_SHIFT: begin
        if (idx == pos) begin
          wr_en            = 1'b1;
          wr_data          = {ins_exp, ins_coeff};
          count_next[tab]  = CW'(n_cur + CW'(1));
          emit_status_next = STAT_NEW;
          state_next       = S_INS_END;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = addr_of(tab, CW'(idx - CW'(1)));
          state_next = S_INS_MOVE;
        end
      end
      S_INS_MOVE: begin
        wr_en      = 1'b1;
        idx_next   = CW'(idx - CW'(1));
        state_next = S_INS_SHIFT;
      end
      S_INS_END: begin
        if (add_mode) begin
          if (emit_status == STAT_FULL) begin
            dropped_next = 1'b1;
          end
          state_next = S_ADD_NEXT;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_ADD_NEXT: begin
        if (src_idx == n_src) begin
          if (src_tab) begin
            emit_status_next = dropped ? STAT_FULL : STAT_ADD;
            add_mode_next    = 1'b0;
            state_next       = S_EMIT;
          end else begin
            src_tab_next = 1'b1;
            src_idx_next = '0;
          end
        end else begin
          rd_en      = 1'b1;
          rd_addr    = addr_of({1'b0, src_tab}, src_idx);
          state_next = S_ADD_FETCH;
        end
      end
      S_ADD_FETCH: begin
        ins_coeff_next = rd_coeff;
        ins_exp_next   = rd_exp;
        tab_next       = TAB_SUM;
        idx_next       = '0;
        src_idx_next   = CW'(src_idx + CW'(1));
        state_next     = S_INS_SCAN;
      end
      S_RD_ISSUE: begin
        rd_en      = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          m_valid_next = 1'b1;
          m_user_next  = {emit_empty, emit_status};
          if (emit_term) begin
            m_data_next = {rd_exp, rd_coeff};
            m_last_next = term_last;
            if (term_last) begin
              state_next = S_IDLE;
            end else begin
              idx_next   = CW'(idx + CW'(1));
              state_next = S_RD_ISSUE;
            end
          end else begin
            m_data_next = '0;
            m_last_next = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> tb/tb_sparse_polynomial_adder.sv
// Self-checking testbench for the sparse polynomial adder: directed table, then random traffic.
module tb_sparse_polynomial_adder;
  timeunit 1ns;
  timeprecision 1ps;

  import spa_pkg::*;

  localparam int TERMS = MAX_TERMS_DEF;
  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int PLAN_ROWS = 21;

  typedef struct packed {
    logic [31:0] coeff;
    logic [7:0]  power;
    logic [2:0]  status;
    logic        is_empty;
    logic        is_last;
  } term_word_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  sel;
    logic [31:0] coeff;
    logic [7:0]  power;
    logic        typed;
    logic [2:0]  want_status;
    logic        want_empty;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [DATA_W-1:0]     s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [DATA_W-1:0]     m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;

  logic [31:0] poly_coeff [3][TERMS];
  logic [7:0]  poly_power [3][TERMS];
  int          poly_len [3] = '{0, 0, 0};

  term_word_t due_words [$];
  term_word_t want_word;
  int         fail_count = 0;
  int         word_count = 0;
  bit         in_quiet = 1'b0;
  bit         out_quiet = 1'b0;
  int         out_count = 0;
  int         out_gap;

  stim_row_t plan [PLAN_ROWS] = '{
    '{CMD_READ,   TAB_A,   32'h0,         8'h00, 1'b1, STAT_READ, 1'b1},
    '{CMD_READ,   TAB_BAD, 32'h0,         8'h00, 1'b1, STAT_READ, 1'b1},
    '{CMD_NOP,    TAB_A,   32'hdead_beef, 8'h5a, 1'b0, STAT_NEW,  1'b0},
    '{CMD_ADD,    TAB_BAD, 32'h0000_1234, 8'h55, 1'b1, STAT_ADD,  1'b0},
    '{CMD_READ,   TAB_SUM, 32'h0,         8'h00, 1'b1, STAT_READ, 1'b1},
    '{CMD_INSERT, TAB_A,   32'h7fff_ffff, 8'h00, 1'b1, STAT_NEW,  1'b0},
    '{CMD_INSERT, TAB_A,   32'h0000_0001, 8'h00, 1'b1, STAT_COMB, 1'b0},
    '{CMD_INSERT, TAB_A,   32'h8000_0000, 8'hff, 1'b1, STAT_NEW,  1'b0},
    '{CMD_INSERT, TAB_A,   32'hffff_ffff, 8'hff, 1'b1, STAT_COMB, 1'b0},
    '{CMD_INSERT, TAB_A,   32'h0000_0040, 8'h80, 1'b0, STAT_NEW,  1'b0},
    '{CMD_INSERT, TAB_B,   32'hffff_fffb, 8'h07, 1'b1, STAT_NEW,  1'b0},
    '{CMD_INSERT, TAB_B,   32'h0000_0005, 8'h07, 1'b1, STAT_COMB, 1'b0},
    '{CMD_INSERT, TAB_B,   32'h8000_0000, 8'h00, 1'b0, STAT_NEW,  1'b0},
    '{CMD_INSERT, TAB_BAD, 32'h5555_aaaa, 8'haa, 1'b1, STAT_FULL, 1'b0},
    '{CMD_READ,   TAB_A,   32'h0,         8'h00, 1'b0, STAT_READ, 1'b0},
    '{CMD_READ,   TAB_B,   32'h0,         8'h00, 1'b0, STAT_READ, 1'b0},
    '{CMD_ADD,    TAB_A,   32'h0,         8'h00, 1'b1, STAT_ADD,  1'b0},
    '{CMD_READ,   TAB_SUM, 32'h0,         8'h00, 1'b0, STAT_READ, 1'b0},
    '{CMD_READ,   TAB_BAD, 32'h0,         8'h00, 1'b0, STAT_READ, 1'b0},
    '{CMD_INSERT, TAB_SUM, 32'h0000_0003, 8'h01, 1'b0, STAT_NEW,  1'b0},
    '{CMD_READ,   TAB_SUM, 32'h0,         8'h00, 1'b0, STAT_READ, 1'b0}
  };

  sparse_polynomial_adder u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic signed [63:0] s;
    s = $signed({{32{a[31]}}, a}) + $signed({{32{b[31]}}, b});
    if (s > 64'sd2147483647) return 32'h7fff_ffff;
    if (s < -64'sd2147483648) return 32'h8000_0000;
    return s[31:0];
  endfunction

  function automatic logic [2:0] place_term(int t, logic [31:0] c, logic [7:0] p);
    int pos;
    pos = 0;
    while (pos < poly_len[t] && poly_power[t][pos] < p) pos++;
    if (pos < poly_len[t] && poly_power[t][pos] == p) begin
      poly_coeff[t][pos] = sat_sum(poly_coeff[t][pos], c);
      return STAT_COMB;
    end
    if (poly_len[t] >= TERMS) return STAT_FULL;
    for (int k = poly_len[t]; k > pos; k--) begin
      poly_coeff[t][k] = poly_coeff[t][k-1];
      poly_power[t][k] = poly_power[t][k-1];
    end
    poly_coeff[t][pos] = c;
    poly_power[t][pos] = p;
    poly_len[t]++;
    return STAT_NEW;
  endfunction

  task automatic poly_apply(input logic [1:0] cmd, input logic [1:0] sel,
                            input logic [31:0] c, input logic [7:0] p,
                            ref term_word_t out[$]);
    term_word_t w;
    int         t;
    logic       dropped;
    out.delete();
    w = '0;
    w.is_last = 1'b1;
    case (cmd)
      CMD_INSERT: begin
        if (sel == TAB_BAD) w.status = STAT_FULL;
        else w.status = place_term(sel, c, p);
        out.push_back(w);
      end
      CMD_ADD: begin
        poly_len[TAB_SUM] = 0;
        dropped = 1'b0;
        for (int s = 0; s < 2; s++) begin
          for (int i = 0; i < poly_len[s]; i++) begin
            if (place_term(TAB_SUM, poly_coeff[s][i], poly_power[s][i]) == STAT_FULL)
              dropped = 1'b1;
          end
        end
        w.status = dropped ? STAT_FULL : STAT_ADD;
        out.push_back(w);
      end
      CMD_READ: begin
        t = (sel == TAB_BAD) ? TAB_SUM : sel;
        w.status = STAT_READ;
        if (poly_len[t] == 0) begin
          w.is_empty = 1'b1;
          out.push_back(w);
        end else begin
          for (int i = 0; i < poly_len[t]; i++) begin
            w.coeff = poly_coeff[t][i];
            w.power = poly_power[t][i];
            w.is_last = (i == poly_len[t] - 1);
            out.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(input logic [1:0] cmd, input logic [1:0] sel,
                           input logic [31:0] c, input logic [7:0] p);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p, c};
    s_tuser  <= {sel, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic run_word(input logic [1:0] cmd, input logic [1:0] sel,
                          input logic [31:0] c, input logic [7:0] p,
                          input logic typed, input logic [2:0] want_status,
                          input logic want_empty);
    term_word_t calc [$];
    term_word_t w;
    if (word_count % 16 == 0) in_quiet = ($urandom_range(0, 3) == 0);
    send_word(cmd, sel, c, p);
    poly_apply(cmd, sel, c, p, calc);
    if (typed) begin
      w = '0;
      w.status = want_status;
      w.is_empty = want_empty;
      w.is_last = 1'b1;
      due_words.push_back(w);
    end else begin
      foreach (calc[i]) due_words.push_back(calc[i]);
    end
    word_count++;
    if (word_count % 64 == 63) drain();
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (due_words.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual data %h user %h last %b",
                 $time, m_tdata, m_tuser, m_tlast);
        fail_count++;
      end else begin
        want_word = due_words.pop_front();
        check_field("coeff_out", want_word.coeff, m_tdata[31:0]);
        check_field("exp_out", 32'(want_word.power), 32'(m_tdata[39:32]));
        check_field("status", 32'(want_word.status), 32'(m_tuser[2:0]));
        check_field("empty_res", 32'(want_word.is_empty), 32'(m_tuser[3]));
        check_field("last", 32'(want_word.is_last), 32'(m_tlast));
      end
    end
  end

  initial begin
    wait (!rst);
    forever begin
      if (out_count % 16 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      out_count++;
      out_gap = out_quiet ? 0 : $urandom_range(0, 14);
      if (out_gap > 0) begin
        m_tready <= 1'b0;
        repeat (out_gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [1:0]  cmd;
    logic [1:0]  sel;
    logic [31:0] c;
    logic [7:0]  p;
    int          r;
    int          counted;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i])
      run_word(plan[i].cmd, plan[i].sel, plan[i].coeff, plan[i].power,
               plan[i].typed, plan[i].want_status, plan[i].want_empty);
    drain();
    // narrow exponent pool first so adds fit, then wide exponents to fill every table
    for (int stage = 0; stage < 2; stage++) begin
      counted = 0;
      while (counted < ((stage == 0) ? 150 : 210)) begin
        r = $urandom_range(0, 99);
        cmd = (r < 62) ? CMD_INSERT : (r < 82) ? CMD_READ : (r < 94) ? CMD_ADD : CMD_NOP;
        sel = ($urandom_range(0, 9) == 0) ? TAB_BAD : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
          0: c = 32'h7fff_ffff;
          1: c = 32'h8000_0000;
          2: c = 32'($urandom_range(0, 20)) - 32'd10;
          default: c = $urandom;
        endcase
        if (stage == 0)
          p = ($urandom_range(0, 10) == 0) ? 8'hff : 8'($urandom_range(0, 9));
        else if (sel != TAB_BAD && poly_len[sel] > 0 && $urandom_range(0, 1) == 1)
          p = poly_power[sel][$urandom_range(0, poly_len[sel] - 1)];
        else
          p = 8'($urandom_range(0, 255));
        run_word(cmd, sel, c, p, 1'b0, STAT_NEW, 1'b0);
        if (cmd != CMD_NOP) counted++;
      end
      drain();
    end
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
